FILE: sv/positional_insert_list_core_defines.svh
// Assertion macros for the positional insert list core.
`ifndef POSITIONAL_INSERT_LIST_CORE_DEFINES_SVH
`define POSITIONAL_INSERT_LIST_CORE_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, off during reset.
`define PIL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pil assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define PIL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pil assertion failed");
`else
`define PIL_ASSERT_IMP(lbl, ante, cons)
`define PIL_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: sv/pil_pkg.sv
// Types and constants shared by the positional insert list core.
package pil_pkg;

    localparam int POS_W  = 5;
    localparam int DATA_W = 32;

    localparam logic [1:0] KIND_INVALID = 2'd0;
    localparam logic [1:0] KIND_FWD     = 2'd1;
    localparam logic [1:0] KIND_BWD     = 2'd2;
    localparam logic [1:0] KIND_FULL    = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [DATA_W-1:0] element;
        logic                     last;
    } out_t;

    typedef struct packed {
        logic       capture;
        logic       insert;
        logic       idx_clr;
        logic       idx_inc;
        logic       idx_dec;
        logic       load_out;
        logic [1:0] kind;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic pos_bad;
        logic full;
        logic fwd_end;
        logic idx_zero;
        logic out_free;
    } status_t;

endpackage

FILE: sv/positional_insert_list_core.sv
// Top level of the positional insert list core.
//
//   channel | signals                      | beat
//   in      | in_valid, in_ready, in_data   | position and value to insert
//   out     | out_valid, out_ready, out_data| kind, element, last
//
// One item at a time: accept, then check and insert, then one result beat per
// cycle from the output register: 2*count beats after a valid insert, one beat
// for a bad position or a full list. Output stalls hold the sequencer. Reset
// clears the count; list entries are never read before being written.
module positional_insert_list_core #(
    parameter int CAPACITY = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  pil_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output pil_pkg::out_t out_data
);
    import pil_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    single_beat;
    logic    single_shape;

    pil_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pil_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // bad position and full list both answer with one bare beat
    assign single_beat  = (out_data.kind == KIND_INVALID) || (out_data.kind == KIND_FULL);
    assign single_shape = out_data.last && (out_data.element == '0);

`include "positional_insert_list_core_defines.svh"

    `PIL_ASSERT_NXT(a_one_item_at_a_time, in_valid && in_ready, !in_ready)
    `PIL_ASSERT_IMP(a_single_result_shape, out_valid && single_beat, single_shape)
    `PIL_ASSERT_IMP(a_fwd_never_last, out_valid && (out_data.kind == KIND_FWD), !out_data.last)
    `PIL_ASSERT_IMP(a_no_load_over_held_beat, cmd.load_out, status.out_free)

endmodule

FILE: sv/pil_dp.sv
// Datapath: list storage, count, read index and output register.
module pil_dp #(
    parameter int CAPACITY = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pil_pkg::in_t     in_data,
    input  pil_pkg::cmd_t    cmd,
    output pil_pkg::status_t status,
    output logic             out_valid,
    input  logic             out_ready,
    output pil_pkg::out_t    out_data
);
    import pil_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic signed [DATA_W-1:0] entries_reg [CAPACITY];
    logic [CW-1:0]            count_reg, count_next;
    logic [IW-1:0]            idx_reg, idx_next;
    logic [POS_W-1:0]         pos_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic                     out_valid_reg, out_valid_next;
    out_t                     out_reg;
    logic [CW-1:0]            count_m1;
    logic                     elem_kind;

    // Shift-up insert: the slot at the position takes the new value, each slot above it its lower neighbor.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
        always_ff @(posedge clk)
        begin
            if (cmd.insert)
            begin
                if (CMPW'(i) == CMPW'(pos_reg))
                begin
                    entries_reg[i] <= val_reg;
                end
                else if (CMPW'(i) > CMPW'(pos_reg))
                begin
                    if (i > 0)
                    begin
                        entries_reg[i] <= entries_reg[(i > 0) ? i - 1 : 0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pos_reg <= in_data.position;
            val_reg <= in_data.value;
        end
        if (cmd.load_out)
        begin
            out_reg.kind    <= cmd.kind;
            out_reg.element <= elem_kind ? entries_reg[idx_reg] : '0;
            out_reg.last    <= cmd.last;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + CW'(1);
        end
        idx_next = idx_reg;
        priority if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + IW'(1);
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_reg - IW'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign count_m1  = count_reg - CW'(1);
    assign elem_kind = (cmd.kind == KIND_FWD) || (cmd.kind == KIND_BWD);

    assign status.pos_bad  = CMPW'(pos_reg) > CMPW'(count_reg);
    assign status.full     = count_reg == CW'(CAPACITY);
    assign status.fwd_end  = CW'(idx_reg) == count_m1;
    assign status.idx_zero = idx_reg == '0;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: sv/pil_ctrl.sv
// Controller: sequences check, insert and the forward/backward readout.
module pil_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pil_pkg::status_t status,
    output pil_pkg::cmd_t    cmd
);
    import pil_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_FWD   = 4'b0100,
        S_BWD   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // invalid position wins over full
                priority if (status.pos_bad)
                begin
                    if (status.out_free)
                    begin
                        cmd.load_out = 1'b1;
                        cmd.kind     = KIND_INVALID;
                        cmd.last     = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else if (status.full)
                begin
                    if (status.out_free)
                    begin
                        cmd.load_out = 1'b1;
                        cmd.kind     = KIND_FULL;
                        cmd.last     = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.insert  = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = S_FWD;
                end
            end
            S_FWD:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.kind     = KIND_FWD;
                    if (status.fwd_end)
                    begin
                        state_next = S_BWD;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_BWD:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.kind     = KIND_BWD;
                    cmd.last     = status.idx_zero;
                    if (status.idx_zero)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_dec = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the positional insert list core.
module tb;
    import pil_pkg::*;

    localparam int CAPACITY  = 16;
    localparam int N_ITEMS   = 500;
    localparam int LIMIT     = 1_000_000;
    localparam int DRAIN     = 40;
    localparam int LONG_HOLD = 300;

    logic clk;
    logic rst_n;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    positional_insert_list_core #(.CAPACITY(CAPACITY)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Predicted list contents and the beats still owed by the block.
    logic signed [DATA_W-1:0] list_vals [CAPACITY];
    int   list_len = 0;
    out_t expected_beats[$];
    in_t  insert_queue[$];

    int   errors      = 0;
    int   accepted_in = 0;
    int   send_gap    = 0;
    logic steady      = 1'b0;   // no new random gaps or stalls start while set
    int   hold_left   = 0;
    bit   held_once   = 1'b0;
    int   beats_seen  = 0;
    int   cycles      = 0;

    function automatic void push_beat(logic [1:0] kind, logic signed [DATA_W-1:0] elem,
                                      logic last);
        out_t beat;
        beat.kind    = kind;
        beat.element = elem;
        beat.last    = last;
        expected_beats.push_back(beat);
    endfunction

    function automatic void predict_insert(in_t item);
        if (item.position > list_len) begin
            push_beat(KIND_INVALID, '0, 1'b1);
        end else if (list_len >= CAPACITY) begin
            push_beat(KIND_FULL, '0, 1'b1);
        end else begin
            for (int i = list_len; i > item.position; i--)
                list_vals[i] = list_vals[i-1];
            list_vals[item.position] = item.value;
            list_len++;
            for (int i = 0; i < list_len; i++)
                push_beat(KIND_FWD, list_vals[i], 1'b0);
            for (int i = list_len - 1; i >= 0; i--)
                push_beat(KIND_BWD, list_vals[i], i == 0);
        end
    endfunction

    function automatic in_t make_insert(int pos, logic [31:0] val);
        in_t item;
        item.position = pos[POS_W-1:0];
        item.value    = val;
        return item;
    endfunction

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Driver: one beat from the queue at a time, random gaps between beats.
    always @(posedge clk) begin
        bit steady_now;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            steady_now = insert_queue.size() < 60 || (accepted_in >= 200 && accepted_in < 260);
            steady <= steady_now;
            if (in_valid && in_ready) begin
                predict_insert(in_data);
                accepted_in++;
                if (!steady_now && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 17);
            end
            if (!(in_valid && !in_ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (insert_queue.size() > 0) begin
                    in_data  <= insert_queue.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each output beat and drives ready with random stalls.
    always @(posedge clk) begin
        out_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                beats_seen++;
                if (expected_beats.size() == 0) begin
                    errors++;
                    $display("%0t unexpected beat: expected none, got kind=%0d element=%0d last=%0b",
                             $time, out_data.kind, out_data.element, out_data.last);
                end else begin
                    want = expected_beats.pop_front();
                    if (out_data.kind !== want.kind || out_data.element !== want.element ||
                        out_data.last !== want.last) begin
                        errors++;
                        $display("%0t mismatch: expected kind=%0d element=%0d last=%0b, got kind=%0d element=%0d last=%0b",
                                 $time, want.kind, want.element, want.last,
                                 out_data.kind, out_data.element, out_data.last);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (!held_once && beats_seen >= 20) begin
                // long back-pressure so the core holds its sequencer and stalls its input
                held_once = 1'b1;
                hold_left = LONG_HOLD - 1;
                out_ready <= 1'b0;
            end else if (!steady && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(1, 17) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int gen_len;
        int pos;
        logic [31:0] val;

        rst_n = 1'b0;

        // directed: bad positions on an empty list, extremes, front/middle/end inserts
        insert_queue.push_back(make_insert(1, 32'd5));
        insert_queue.push_back(make_insert(31, 32'hFFFF_FFFF));
        insert_queue.push_back(make_insert(16, 32'h0000_0001));
        insert_queue.push_back(make_insert(0, 32'h7FFF_FFFF));
        insert_queue.push_back(make_insert(1, 32'h8000_0000));
        insert_queue.push_back(make_insert(0, 32'h0000_0000));
        insert_queue.push_back(make_insert(1, 32'hFFFF_FFFF));
        insert_queue.push_back(make_insert(5, 32'h1234_5678));
        insert_queue.push_back(make_insert(4, 32'hAAAA_5555));
        gen_len = 5;

        // random: mostly legal positions so the list fills and full cases follow; bad positions throughout
        while (insert_queue.size() < N_ITEMS) begin
            if ($urandom_range(0, 4) != 0)
                pos = $urandom_range(0, gen_len);
            else
                pos = $urandom_range(0, 31);
            case ($urandom_range(0, 7))
                0: val = 32'h7FFF_FFFF;
                1: val = 32'h8000_0000;
                default: val = $urandom;
            endcase
            insert_queue.push_back(make_insert(pos, val));
            if (pos <= gen_len && gen_len < CAPACITY)
                gen_len++;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_in < N_ITEMS) @(posedge clk);
        while (expected_beats.size() > 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
